// ===== rtl/core/plb_pkg.sv =====
// ============================================================================
// plb_pkg
// Shared types, constants and lookup tables of the printer line buffer.
// ============================================================================
package plb_pkg;

  // Line geometry.
  localparam int LINE_LENGTH = 20;
  localparam int IDX_W       = $clog2(LINE_LENGTH);
  localparam int HEAD_RESET  = (5 < LINE_LENGTH) ? 5 : (LINE_LENGTH - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LINE_LENGTH - 1);

  // Characters used by the buffer itself.
  localparam logic [7:0] CHAR_RESET = 8'h58;  // 'X'
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NONE  = 8'h00;

  // Printer kinds.
  localparam logic [1:0] KIND_A08 = 2'd0;
  localparam logic [1:0] KIND_B06 = 2'd1;

  // Instruction word matching.
  localparam logic [15:0] MATCH_MASK = 16'hFF0F;
  localparam logic [15:0] MATCH_08   = 16'h0A08;
  localparam logic [15:0] MATCH_06   = 16'h0A06;

  localparam logic [15:0] IRG_CHAR_8  = 16'h0A68;
  localparam logic [15:0] IRG_CHAR_6  = 16'h0A66;
  localparam logic [15:0] IRG_FUNC_8  = 16'h0A78;
  localparam logic [15:0] IRG_FUNC_6  = 16'h0A76;
  localparam logic [15:0] IRG_CLEAR_8 = 16'h0A88;
  localparam logic [15:0] IRG_CLEAR_6 = 16'h0A86;
  localparam logic [15:0] IRG_STEP_8  = 16'h0A98;
  localparam logic [15:0] IRG_STEP_6  = 16'h0A96;
  localparam logic [15:0] IRG_PRINT_P = 16'h0AA8;
  localparam logic [15:0] IRG_PRINT_D = 16'h0AA6;
  localparam logic [15:0] IRG_FEED    = 16'h0AB8;

  localparam logic [3:0] BUS_STATE_ACT = 4'd15;

  // Queue capacity for finished results, counting reads still in flight.
  localparam logic [1:0] QUEUE_SLOTS = 2'd2;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CHAR,
    CMD_FUNC,
    CMD_CLEAR,
    CMD_STEP,
    CMD_PRINT,
    CMD_FEED
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FN1,
    ST_FN0,
    ST_PRINT
  } state_t;

  typedef struct packed {
    logic [3:0]  bus_state;
    logic        bus_is_write;
    logic [15:0] instruction_word;
    logic [15:0] external_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       destination;
    logic       blank_line;
    logic       last_of_line;
  } out_item_t;

  // Result under way: travels alongside the buffer read of the same cycle.
  typedef struct packed {
    logic       valid;
    logic       use_fill;
    logic [7:0] fill;
    logic       destination;
    logic       blank_line;
    logic       last_of_line;
  } pend_t;

  // Output queue status seen by the controller.
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } qstat_t;

  // Fonts, first character in the most significant byte.
  localparam logic [8*64-1:0] FONT_A = {
    " 0123456", "789ABCDE", "-FGHIJKL", "MNOPQRST",
    ".UVWXYZ+", "x*spe(),", "^%|/='#~", "z?:!]\"[$"
  };

  localparam logic [8*64-1:0] FONT_B = {
    " 0123456", "789.z#!\"", "=-+:x'~)", "s^$[/|e]",
    "QRSTUVWX", "YZ*p?,%(", "ABCDEFGH", "IJKLMNOP"
  };

  function automatic logic [7:0] font_char(input logic use_a, input logic [5:0] code);
    logic [8:0] sel;
    sel = {6'd63 - code, 3'b000};
    return use_a ? FONT_A[sel +: 8] : FONT_B[sel +: 8];
  endfunction

  // Function mnemonics; the leftmost character sits in bits 23:16.
  // An unknown code gives three question marks.
  function automatic logic [23:0] mnem_text(input logic [6:0] code);
    logic [23:0] txt;
    case (code)
      7'h00: txt = "   ";
      7'h11: txt = " = ";
      7'h12: txt = " - ";
      7'h13: txt = " + ";
      7'h16: txt = " / ";
      7'h17: txt = " x ";
      7'h1A: txt = "xsY";
      7'h1B: txt = "Y^x";
      7'h21: txt = "CLR";
      7'h22: txt = "INV";
      7'h23: txt = "DPT";
      7'h26: txt = "CE ";
      7'h27: txt = "+/-";
      7'h2D: txt = "EE ";
      7'h31: txt = "e^x";
      7'h33: txt = "x^2";
      7'h36: txt = "1/x";
      7'h3C: txt = "sX ";
      7'h3D: txt = "X|Y";
      7'h51: txt = "LNX";
      7'h53: txt = "PRM";
      7'h54: txt = " % ";
      7'h56: txt = "COS";
      7'h57: txt = "SIN";
      7'h5D: txt = "TAN";
      7'h61: txt = "SUM";
      7'h66: txt = "STO";
      7'h67: txt = "pi ";
      7'h68: txt = "RCL";
      7'h69: txt = "$+ ";
      7'h70: txt = "ERR";
      7'h71: txt = " ( ";
      7'h72: txt = " ) ";
      7'h73: txt = "LRN";
      7'h74: txt = "RUN";
      7'h76: txt = "HLT";
      7'h78: txt = "STP";
      7'h7A: txt = "GTO";
      7'h7C: txt = "IF ";
      default: txt = "???";
    endcase
    return txt;
  endfunction

endpackage

// ===== rtl/core/calculator_printer_line_buffer.sv =====
// ============================================================================
// calculator_printer_line_buffer
// Twenty-character line buffer of a calculator printer with print and feed.
// ============================================================================
// Load character, clear, step and ignored items are handled in ST_IDLE;
// load function writes in ST_IDLE, ST_FN1 and ST_FN0, one buffer write each,
// and stalls the input meanwhile. A feed result passes through the pend
// register and the result queue; a print reads one character per cycle in
// ST_PRINT while the queue has room, each through the same two registers.
// Reset is synchronous: cleared written flags make the buffer read as 'X'.
module calculator_printer_line_buffer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  plb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output plb_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata
);

  // The character store is one RAM with a write port for the head and a
  // read port for the print sequencer. Only the controller touches it, and
  // it never writes and reads in the same cycle, so a write is always seen
  // by any later print without forwarding.
  logic                       ram_we;
  logic [plb_pkg::IDX_W-1:0]  ram_waddr;
  logic [7:0]                 ram_wdata;
  logic                       ram_re;
  logic [plb_pkg::IDX_W-1:0]  ram_raddr;
  logic [7:0]                 ram_rdata;
  plb_pkg::pend_t             pend;
  plb_pkg::qstat_t            qstat;

  // The controller decodes commands, moves the head, tracks which entries
  // hold a written character, and steps through the line during a print.
  plb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .pend      (pend),
    .qstat     (qstat)
  );

  plb_ram #(
    .WIDTH (8),
    .DEPTH (plb_pkg::LINE_LENGTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The result queue takes the read data in the cycle after the read, together
  // with the result fields that the controller sent along. Its two entries
  // let the block take the next transfer while a result still waits.
  plb_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .pend      (pend),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .qstat     (qstat)
  );

  // The buffer is either written or read in a cycle, never both.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("buffer written and read in the same cycle");

  // While the print sequencer reads, no new transfer is taken.
  a_print_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> in_stall)
    else $error("input taken during a print");

  // The queue never holds more than its two entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count != 2'd3)
    else $error("result queue overflow");

  // A result that uses buffer data must follow a buffer read.
  a_read_before_use: assert property (@(posedge clk) disable iff (!rst_n)
    (pend.valid && !pend.use_fill) |-> $past(ram_re))
    else $error("buffer data used without a read");

endmodule

// ===== rtl/core/plb_ram.sv =====
// ============================================================================
// plb_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module plb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/plb_ctrl.sv =====
// ============================================================================
// plb_ctrl
// Command decode, write head, written flags and print read sequencer.
// ============================================================================
module plb_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  plb_pkg::in_item_t        in_data,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_wdata,
  output logic                     ram_we,
  output logic [plb_pkg::IDX_W-1:0] ram_waddr,
  output logic [7:0]               ram_wdata,
  output logic                     ram_re,
  output logic [plb_pkg::IDX_W-1:0] ram_raddr,
  output plb_pkg::pend_t           pend,
  input  plb_pkg::qstat_t          qstat
);

  plb_pkg::state_t                 state_r, state_nxt;
  logic [plb_pkg::IDX_W-1:0]       head_r, head_nxt;
  logic [plb_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [plb_pkg::LINE_LENGTH-1:0] written_r, written_nxt;
  logic [7:0]                      fill_r, fill_nxt;
  logic [1:0]                      kind_r, kind_nxt;
  logic [15:0]                     txt_r, txt_nxt;
  logic                            dest_r, dest_nxt;
  plb_pkg::pend_t                  pend_r, pend_nxt;

  logic [1:0]                      slots;
  logic                            slot_ok;
  logic                            accept;
  logic [15:0]                     match;
  logic                            use_a;
  plb_pkg::cmd_t                   cmd;
  logic [plb_pkg::IDX_W-1:0]       head_dec;
  logic [23:0]                     mnem;

  function automatic plb_pkg::cmd_t decode(input logic [15:0] irg);
    plb_pkg::cmd_t c;
    case (irg)
      plb_pkg::IRG_CHAR_8,  plb_pkg::IRG_CHAR_6:  c = plb_pkg::CMD_CHAR;
      plb_pkg::IRG_FUNC_8,  plb_pkg::IRG_FUNC_6:  c = plb_pkg::CMD_FUNC;
      plb_pkg::IRG_CLEAR_8, plb_pkg::IRG_CLEAR_6: c = plb_pkg::CMD_CLEAR;
      plb_pkg::IRG_STEP_8,  plb_pkg::IRG_STEP_6:  c = plb_pkg::CMD_STEP;
      plb_pkg::IRG_PRINT_P, plb_pkg::IRG_PRINT_D: c = plb_pkg::CMD_PRINT;
      plb_pkg::IRG_FEED:                          c = plb_pkg::CMD_FEED;
      default:                                    c = plb_pkg::CMD_NONE;
    endcase
    return c;
  endfunction

  // A result may start only if the queue has room counting the read in flight.
  assign slots   = qstat.count + {1'b0, pend_r.valid};
  assign slot_ok = (slots < plb_pkg::QUEUE_SLOTS) ||
                   ((slots == plb_pkg::QUEUE_SLOTS) && qstat.pop);

  assign in_stall = !((state_r == plb_pkg::ST_IDLE) && slot_ok);
  assign accept   = in_valid && !in_stall;

  assign match = (kind_r == plb_pkg::KIND_B06) ? plb_pkg::MATCH_06 : plb_pkg::MATCH_08;
  assign use_a = (kind_r == plb_pkg::KIND_A08);

  assign cmd = (accept && (in_data.bus_state == plb_pkg::BUS_STATE_ACT) &&
                !in_data.bus_is_write &&
                ((in_data.instruction_word & plb_pkg::MATCH_MASK) == match))
               ? decode(in_data.instruction_word) : plb_pkg::CMD_NONE;

  assign head_dec = (head_r == '0) ? plb_pkg::IDX_LAST : head_r - 1'b1;
  assign mnem     = plb_pkg::mnem_text(in_data.external_bits[9:3]);

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    idx_nxt     = idx_r;
    written_nxt = written_r;
    fill_nxt    = fill_r;
    txt_nxt     = txt_r;
    dest_nxt    = dest_r;
    kind_nxt    = cfg_we ? cfg_wdata : kind_r;
    pend_nxt    = '0;
    ram_we      = 1'b0;
    ram_waddr   = head_r;
    ram_wdata   = plb_pkg::CHAR_NONE;
    ram_re      = 1'b0;
    ram_raddr   = idx_r;

    case (state_r)
      plb_pkg::ST_IDLE: begin
        case (cmd)
          plb_pkg::CMD_CHAR: begin
            ram_we              = 1'b1;
            ram_wdata           = plb_pkg::font_char(use_a, in_data.external_bits[8:3]);
            written_nxt[head_r] = 1'b1;
            head_nxt            = head_dec;
          end
          plb_pkg::CMD_FUNC: begin
            // The mnemonic goes in last character first.
            ram_we              = 1'b1;
            ram_wdata           = mnem[7:0];
            txt_nxt             = mnem[23:8];
            written_nxt[head_r] = 1'b1;
            head_nxt            = head_dec;
            state_nxt           = plb_pkg::ST_FN1;
          end
          plb_pkg::CMD_CLEAR: begin
            written_nxt = '0;
            fill_nxt    = plb_pkg::CHAR_SPACE;
            head_nxt    = plb_pkg::IDX_LAST;
          end
          plb_pkg::CMD_STEP: begin
            head_nxt = head_dec;
          end
          plb_pkg::CMD_PRINT: begin
            idx_nxt   = '0;
            dest_nxt  = (in_data.instruction_word == plb_pkg::IRG_PRINT_D);
            state_nxt = plb_pkg::ST_PRINT;
          end
          plb_pkg::CMD_FEED: begin
            pend_nxt.valid        = 1'b1;
            pend_nxt.use_fill     = 1'b1;
            pend_nxt.fill         = plb_pkg::CHAR_NONE;
            pend_nxt.blank_line   = 1'b1;
            pend_nxt.last_of_line = 1'b1;
          end
          default: begin
          end
        endcase
      end
      plb_pkg::ST_FN1: begin
        ram_we              = 1'b1;
        ram_wdata           = txt_r[7:0];
        written_nxt[head_r] = 1'b1;
        head_nxt            = head_dec;
        state_nxt           = plb_pkg::ST_FN0;
      end
      plb_pkg::ST_FN0: begin
        ram_we              = 1'b1;
        ram_wdata           = txt_r[15:8];
        written_nxt[head_r] = 1'b1;
        head_nxt            = head_dec;
        state_nxt           = plb_pkg::ST_IDLE;
      end
      plb_pkg::ST_PRINT: begin
        if (slot_ok) begin
          // Entries never written since reset or clear read as the fill character.
          ram_re                = 1'b1;
          pend_nxt.valid        = 1'b1;
          pend_nxt.use_fill     = !written_r[idx_r];
          pend_nxt.fill         = fill_r;
          pend_nxt.destination  = dest_r;
          pend_nxt.last_of_line = (idx_r == plb_pkg::IDX_LAST);
          if (idx_r == plb_pkg::IDX_LAST) begin
            state_nxt = plb_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = plb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= plb_pkg::ST_IDLE;
      head_r    <= plb_pkg::IDX_W'(plb_pkg::HEAD_RESET);
      written_r <= '0;
      fill_r    <= plb_pkg::CHAR_RESET;
      kind_r    <= plb_pkg::KIND_A08;
      pend_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      written_r <= written_nxt;
      fill_r    <= fill_nxt;
      kind_r    <= kind_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    txt_r  <= txt_nxt;
    dest_r <= dest_nxt;
  end

  assign pend = pend_r;

endmodule

// ===== rtl/core/plb_outq.sv =====
// ============================================================================
// plb_outq
// Two-entry result queue that decouples the buffer reads from the output.
// ============================================================================
module plb_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  plb_pkg::pend_t     pend,
  input  logic [7:0]         ram_rdata,
  output logic               out_valid,
  input  logic               out_stall,
  output plb_pkg::out_item_t out_data,
  output plb_pkg::qstat_t    qstat
);

  plb_pkg::out_item_t q0_r, q0_nxt;
  plb_pkg::out_item_t q1_r, q1_nxt;
  logic [1:0]         count_r, count_nxt;
  plb_pkg::out_item_t push_item;
  logic               push;
  logic               pop;

  assign push                   = pend.valid;
  assign push_item.char_code    = pend.use_fill ? pend.fill : ram_rdata;
  assign push_item.destination  = pend.destination;
  assign push_item.blank_line   = pend.blank_line;
  assign push_item.last_of_line = pend.last_of_line;

  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && !out_stall;

  always_comb begin
    q0_nxt    = q0_r;
    q1_nxt    = q1_r;
    count_nxt = count_r;
    case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) begin
          q0_nxt = push_item;
        end else begin
          q1_nxt = push_item;
        end
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        q0_nxt    = q1_r;
        count_nxt = count_r - 2'd1;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          q0_nxt = push_item;
        end else begin
          q0_nxt = q1_r;
          q1_nxt = push_item;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_data    = q0_r;
  assign qstat.count = count_r;
  assign qstat.pop   = pop;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Printer line buffer testbench
// Runs a stimulus table and then random command streams through the line
// buffer. It expects every printed character and feed marker, from the
// predictor or the table, and checks each result against the oldest one.
// ----------------------------------------------------------------------------
module tb;
  import plb_pkg::*;

  // Printer kinds that the package does not name. Kind 3 decodes as kind 2.
  localparam logic [1:0] KIND_B08     = 2'd2;
  localparam logic [1:0] KIND_B08_ALT = 2'd3;

  // A word that passes the match pattern but selects no command.
  localparam logic [15:0] IRG_UNUSED_8 = 16'h0AC8;

  localparam logic [7:0] CHAR_UNKNOWN = "?";

  localparam int MNEM_COUNT      = 39;
  localparam int ITEMS_PER_PHASE = 22;
  // Idle cycles before a register write: covers the function load.
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_CYCLES     = 400;
  // Watchdog time limit in nanoseconds.
  localparam longint WATCHDOG_NS = 64'd3_000_000;

  // How a row of the stimulus table is checked.
  typedef enum logic [1:0] {
    ROW_MODEL,   // expected results come from the predictor
    ROW_LINE,    // a print whose twenty characters are all the same
    ROW_FEED,    // a single blank-line marker
    ROW_CONFIG   // a write of the printer kind
  } row_check_t;

  typedef struct packed {
    row_check_t check;
    in_item_t   item;
    logic [7:0] fill;
    logic       dest;
    logic [1:0] kind;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_wdata;

  // Set during one random phase: neither side idles at all.
  logic steady;
  // Raised once by the sender; the receiver then holds off for a long stretch.
  logic hold_request;

  int mismatches = 0;

  // Predicted printer state, kept alongside the block.
  logic [7:0] model_line [LINE_LENGTH];
  logic [4:0] model_head;
  logic [1:0] model_kind;

  // Characters and markers still owed by the block, oldest first.
  out_item_t expected_prints [$];

  // The two fonts, indexed by the 6-bit character code.
  string glyphs_a =
    " 0123456789ABCDE-FGHIJKLMNOPQRST.UVWXYZ+x*spe(),^%|/='#~z?:!]\"[$";
  string glyphs_b =
    " 0123456789.z#!\"=-+:x'~)s^$[/|e]QRSTUVWXYZ*p?,%(ABCDEFGHIJKLMNOP";

  // Function codes and their three-character mnemonics, three bytes each.
  logic [6:0] mnem_code [MNEM_COUNT] = '{
    7'h00, 7'h11, 7'h12, 7'h13, 7'h16, 7'h17, 7'h1A, 7'h1B,
    7'h21, 7'h22, 7'h23, 7'h26, 7'h27, 7'h2D, 7'h31, 7'h33,
    7'h36, 7'h3C, 7'h3D, 7'h51, 7'h53, 7'h54, 7'h56, 7'h57,
    7'h5D, 7'h61, 7'h66, 7'h67, 7'h68, 7'h69, 7'h70, 7'h71,
    7'h72, 7'h73, 7'h74, 7'h76, 7'h78, 7'h7A, 7'h7C
  };
  string mnem_text = {
    "   ", " = ", " - ", " + ", " / ", " x ", "xsY", "Y^x",
    "CLR", "INV", "DPT", "CE ", "+/-", "EE ", "e^x", "x^2",
    "1/x", "sX ", "X|Y", "LNX", "PRM", " % ", "COS", "SIN",
    "TAN", "SUM", "STO", "pi ", "RCL", "$+ ", "ERR", " ( ",
    " ) ", "LRN", "RUN", "HLT", "STP", "GTO", "IF "
  };

  // The stimulus table. It opens in kind 0 straight after reset, where the
  // line still reads as all 'X' and the head sits at 5. The function loads
  // walk the head down through 0 so that it wraps to the end of the line.
  row_t directed [25] = '{
    '{ROW_LINE,   '{BUS_STATE_ACT, 1'b0, IRG_PRINT_P,  16'h0000}, CHAR_RESET, 1'b0, KIND_A08},
    '{ROW_FEED,   '{BUS_STATE_ACT, 1'b0, IRG_FEED,     16'hFFFF}, CHAR_NONE,  1'b0, KIND_A08},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_CHAR_8,   16'h0000}, CHAR_NONE,  1'b0, KIND_A08},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_CHAR_8,   16'hFFFF}, CHAR_NONE,  1'b0, KIND_A08},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_FUNC_8,   16'h0108}, CHAR_NONE,  1'b0, KIND_A08},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_FUNC_8,   16'h03F8}, CHAR_NONE,  1'b0, KIND_A08},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_STEP_8,   16'h0000}, CHAR_NONE,  1'b0, KIND_A08},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_PRINT_P,  16'h0000}, CHAR_NONE,  1'b0, KIND_A08},
    // Rejected: wrong bus state, a write cycle, the other pattern, an unused
    // command and an all-ones word.
    '{ROW_MODEL,  '{4'd14,         1'b0, IRG_PRINT_P,  16'h0000}, CHAR_NONE,  1'b0, KIND_A08},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b1, IRG_PRINT_P,  16'h0000}, CHAR_NONE,  1'b0, KIND_A08},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_PRINT_D,  16'h0000}, CHAR_NONE,  1'b0, KIND_A08},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_UNUSED_8, 16'h0000}, CHAR_NONE,  1'b0, KIND_A08},
    '{ROW_MODEL,  '{4'd0,          1'b1, 16'hFFFF,     16'hFFFF}, CHAR_NONE,  1'b0, KIND_A08},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_CLEAR_8,  16'h0000}, CHAR_NONE,  1'b0, KIND_A08},
    '{ROW_LINE,   '{BUS_STATE_ACT, 1'b0, IRG_PRINT_P,  16'h0000}, CHAR_SPACE, 1'b0, KIND_A08},
    // Kind 1: the other pattern, font B, print to the display.
    '{ROW_CONFIG, '0,                                             CHAR_NONE,  1'b0, KIND_B06},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_CHAR_6,   16'hFFFF}, CHAR_NONE,  1'b0, KIND_B06},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_FUNC_6,   16'hFFFF}, CHAR_NONE,  1'b0, KIND_B06},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_STEP_6,   16'h0000}, CHAR_NONE,  1'b0, KIND_B06},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_CLEAR_6,  16'h0000}, CHAR_NONE,  1'b0, KIND_B06},
    '{ROW_LINE,   '{BUS_STATE_ACT, 1'b0, IRG_PRINT_D,  16'h0000}, CHAR_SPACE, 1'b1, KIND_B06},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_FEED,     16'h0000}, CHAR_NONE,  1'b0, KIND_B06},
    // Kind 3 decodes like kind 2.
    '{ROW_CONFIG, '0,                                             CHAR_NONE,  1'b0, KIND_B08_ALT},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_CHAR_8,   16'h01F8}, CHAR_NONE,  1'b0, KIND_B08_ALT},
    '{ROW_MODEL,  '{BUS_STATE_ACT, 1'b0, IRG_PRINT_P,  16'h0000}, CHAR_NONE,  1'b0, KIND_B08_ALT}
  };

  // Printer kinds of the random phases, in order.
  logic [1:0] phase_kinds [5] = '{KIND_B08, KIND_B06, KIND_A08, KIND_B08_ALT, KIND_B08};

  calculator_printer_line_buffer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Line buffer predictor
  // --------------------------------------------------------------------------

  // The head moves down one slot and wraps from the first slot to the last.
  task automatic head_advance();
    if (model_head == 0 || model_head >= LINE_LENGTH) begin
      model_head = 5'(LINE_LENGTH - 1);
    end else begin
      model_head = model_head - 5'd1;
    end
  endtask

  task automatic head_write(input logic [7:0] c);
    if (model_head < LINE_LENGTH) begin
      model_line[model_head] = c;
    end
  endtask

  // Applies one transfer to the predicted line. With record set, the
  // characters and markers it prints are queued. Acted tells whether the
  // transfer selected one of the commands.
  task automatic predict_printer(input in_item_t item, input bit record, output bit acted);
    logic [15:0] pattern;
    bit          use_font_a;
    int          idx;
    int          slot;
    bit          found;
    logic [6:0]  code;
    out_item_t   res;
    acted      = 1'b0;
    pattern    = (model_kind == KIND_B06) ? MATCH_06 : MATCH_08;
    use_font_a = (model_kind == KIND_A08);
    if (item.bus_state != BUS_STATE_ACT || item.bus_is_write) begin
      return;
    end
    if ((item.instruction_word & MATCH_MASK) != pattern) begin
      return;
    end
    case (item.instruction_word)
      IRG_CHAR_8, IRG_CHAR_6: begin
        idx = int'(item.external_bits[8:3]);
        head_write(use_font_a ? glyphs_a[idx] : glyphs_b[idx]);
        head_advance();
        acted = 1'b1;
      end
      IRG_FUNC_8, IRG_FUNC_6: begin
        // The mnemonic goes in last character first, so it reads left to
        // right once the head has moved down past it.
        code  = item.external_bits[9:3];
        found = 1'b0;
        slot  = 0;
        for (int k = 0; k < MNEM_COUNT; k++) begin
          if (!found && mnem_code[k] == code) begin
            found = 1'b1;
            slot  = k;
          end
        end
        for (int j = 2; j >= 0; j--) begin
          head_write(found ? mnem_text[3 * slot + j] : CHAR_UNKNOWN);
          head_advance();
        end
        acted = 1'b1;
      end
      IRG_CLEAR_8, IRG_CLEAR_6: begin
        foreach (model_line[i]) model_line[i] = CHAR_SPACE;
        model_head = 5'(LINE_LENGTH - 1);
        acted = 1'b1;
      end
      IRG_STEP_8, IRG_STEP_6: begin
        head_advance();
        acted = 1'b1;
      end
      IRG_PRINT_P, IRG_PRINT_D: begin
        for (int i = 0; i < LINE_LENGTH; i++) begin
          res.char_code    = model_line[i];
          res.destination  = (item.instruction_word == IRG_PRINT_D);
          res.blank_line   = 1'b0;
          res.last_of_line = (i == LINE_LENGTH - 1);
          if (record) expected_prints.push_back(res);
        end
        acted = 1'b1;
      end
      IRG_FEED: begin
        res = '{char_code: CHAR_NONE, destination: 1'b0, blank_line: 1'b1,
                last_of_line: 1'b1};
        if (record) expected_prints.push_back(res);
        acted = 1'b1;
      end
      default: begin
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Random transfer for the given kind. Most are well-formed commands with
  // random payload, some carry the other kind's suffix and are rejected,
  // and the rest is noise on every field.
  function automatic in_item_t random_transfer(input logic [1:0] kind);
    in_item_t item;
    int       pick;
    bit       six;
    pick = $urandom_range(99);
    six  = (kind == KIND_B06);
    if ($urandom_range(9) == 0) six = !six;
    item.bus_state        = BUS_STATE_ACT;
    item.bus_is_write     = 1'b0;
    item.instruction_word = 16'h0000;
    item.external_bits    = 16'($urandom());
    if (pick < 30) begin
      item.instruction_word = six ? IRG_CHAR_6 : IRG_CHAR_8;
    end else if (pick < 50) begin
      item.instruction_word = six ? IRG_FUNC_6 : IRG_FUNC_8;
      // Mostly known function codes, with random bits around the code.
      if ($urandom_range(99) < 70) begin
        item.external_bits[9:3] = mnem_code[$urandom_range(MNEM_COUNT - 1)];
      end
    end else if (pick < 60) begin
      item.instruction_word = six ? IRG_STEP_6 : IRG_STEP_8;
    end else if (pick < 65) begin
      item.instruction_word = six ? IRG_CLEAR_6 : IRG_CLEAR_8;
    end else if (pick < 80) begin
      item.instruction_word = six ? IRG_PRINT_D : IRG_PRINT_P;
    end else if (pick < 90) begin
      item.instruction_word = IRG_FEED;
    end else begin
      item.bus_state    = 4'($urandom());
      item.bus_is_write = 1'($urandom());
      if ($urandom_range(1) == 0) begin
        item.instruction_word = 16'($urandom());
      end else begin
        // Near the command space: right high byte, random low byte.
        item.instruction_word = {MATCH_08[15:8], 8'($urandom())};
      end
    end
    return item;
  endfunction

  // Offers one transfer, idling at random before it, and predicts its
  // results at the edge where it is accepted.
  task automatic send_transfer(input in_item_t item, input bit record, output bit acted);
    while (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_printer(item, record, acted);
  endtask

  // Writes the printer kind once the block has gone quiet: every expected
  // result is in, and SETTLE_CYCLES more let a command with no result finish.
  task automatic program_kind(input logic [1:0] kind);
    in_valid <= 1'b0;
    while (expected_prints.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= kind;
    @(posedge clk);
    cfg_we     <= 1'b0;
    model_kind = kind;
  endtask

  // Compares one result with the oldest prediction, field by field.
  task automatic check_print(input out_item_t got);
    out_item_t want;
    if (expected_prints.size() == 0) begin
      mismatches++;
      $error("unexpected result: char_code %h blank_line %b", got.char_code,
             got.blank_line);
      return;
    end
    want = expected_prints.pop_front();
    if (got.char_code !== want.char_code) begin
      mismatches++;
      $error("char_code: expected %h, actual %h", want.char_code, got.char_code);
    end
    if (got.destination !== want.destination) begin
      mismatches++;
      $error("destination: expected %b, actual %b", want.destination, got.destination);
    end
    if (got.blank_line !== want.blank_line) begin
      mismatches++;
      $error("blank_line: expected %b, actual %b", want.blank_line, got.blank_line);
    end
    if (got.last_of_line !== want.last_of_line) begin
      mismatches++;
      $error("last_of_line: expected %b, actual %b", want.last_of_line,
             got.last_of_line);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: reset, the stimulus table, then the random phases.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    bit acted;
    int acted_items;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = KIND_A08;
    steady       = 1'b0;
    hold_request = 1'b0;
    foreach (model_line[i]) model_line[i] = CHAR_RESET;
    model_head = 5'(HEAD_RESET);
    model_kind = KIND_A08;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table. Rows with results that are plain to see get them
    // typed in here; the predictor still follows them to keep its state.
    foreach (directed[r]) begin
      if (directed[r].check == ROW_CONFIG) begin
        program_kind(directed[r].kind);
      end else begin
        send_transfer(directed[r].item, directed[r].check == ROW_MODEL, acted);
        if (directed[r].check == ROW_LINE) begin
          for (int i = 0; i < LINE_LENGTH; i++) begin
            expected_prints.push_back('{char_code: directed[r].fill,
                                        destination: directed[r].dest,
                                        blank_line: 1'b0,
                                        last_of_line: (i == LINE_LENGTH - 1)});
          end
        end else if (directed[r].check == ROW_FEED) begin
          expected_prints.push_back('{char_code: CHAR_NONE, destination: 1'b0,
                                      blank_line: 1'b1, last_of_line: 1'b1});
        end
      end
    end

    // Random phases, one per printer kind setting. Only transfers that
    // select a command count toward a phase. The third phase runs with no
    // idling on either side; the second asks the receiver for a long hold.
    foreach (phase_kinds[p]) begin
      program_kind(phase_kinds[p]);
      steady <= (p == 2);
      acted_items = 0;
      while (acted_items < ITEMS_PER_PHASE) begin
        if (p == 1 && acted_items == 8) hold_request <= 1'b1;
        send_transfer(random_transfer(phase_kinds[p]), 1'b1, acted);
        if (acted) acted_items++;
      end
    end

    // Drain: wait for every owed result, then a margin in which any stray
    // result would show up as unexpected.
    in_valid <= 1'b0;
    while (expected_prints.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[calculator_printer_line_buffer] OK");
    end else begin
      $display("[calculator_printer_line_buffer] ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: checks each accepted result and drives out_stall. It idles at
  // random, except in the steady phase, and once holds off for a long
  // counted stretch so that the block backs up and stalls its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        check_print(out_data);
      end
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 30);
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("[calculator_printer_line_buffer] ERROR");
    $finish;
  end

endmodule

// ===== calculator_printer_line_buffer.f =====
rtl/core/plb_pkg.sv
rtl/core/plb_ram.sv
rtl/core/plb_ctrl.sv
rtl/core/plb_outq.sv
rtl/core/calculator_printer_line_buffer.sv
dv/tb.sv
